/* sv/dfu_pkg.sv */
package dfu_pkg;

	// Opcodes of the event stream
	typedef enum logic [3:0] {
		OP_TICK       = 4'd0,
		OP_DNLOAD     = 4'd1,
		OP_DATA_RCVD  = 4'd2,
		OP_GET_STATUS = 4'd3,
		OP_GET_STATE  = 4'd4,
		OP_CLR_STATUS = 4'd5,
		OP_ABORT      = 4'd6,
		OP_SET_INTF   = 4'd7,
		OP_GET_INTF   = 4'd8,
		OP_UNKNOWN    = 4'd9
	} opcode_t;

	// DFU states, standard numbering
	typedef enum logic [3:0] {
		ST_APP_IDLE = 4'd0,
		ST_IDLE     = 4'd2,
		ST_DN_SYNC  = 4'd3,
		ST_DN_BUSY  = 4'd4,
		ST_DN_IDLE  = 4'd5,
		ST_MF_SYNC  = 4'd6,
		ST_MF       = 4'd7
	} usb_state_t;

	// Flash work phase
	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_ERASE   = 2'd1,
		PH_PROGRAM = 2'd2
	} phase_t;

	// Flash command issued on a tick
	typedef enum logic [1:0] {
		CMD_NONE    = 2'd0,
		CMD_ERASE   = 2'd1,
		CMD_PROGRAM = 2'd2
	} flash_cmd_t;

	// Flash geometry and buffer size
	localparam int unsigned SECTOR_BYTES = 4096;
	localparam int unsigned PAGE_BYTES   = 256;
	localparam int unsigned PAGE_W       = 8;
	localparam int unsigned BUF_BYTES    = 4096;

	// Slot layout: base = (512 + slot * 128) KiB
	localparam logic [31:0] SLOT_ORIGIN = 32'(512 * 1024);
	localparam int unsigned SLOT_SHIFT  = 17;

	// Interface identity
	localparam logic [7:0] INTF_CLASS    = 8'hfe;
	localparam logic [7:0] INTF_SUBCLASS = 8'h01;
	localparam logic [7:0] INTF_PROTOCOL = 8'h02;

	// Input payload, last member in the lowest bits
	typedef struct packed {
		logic       flash_busy;
		logic [7:0] intf_protocol;
		logic [7:0] intf_subclass;
		logic [7:0] intf_class;
		logic [7:0] alt_setting;
		logic [12:0] length;
	} in_data_t;

	// Result payload, last member in the lowest bits
	typedef struct packed {
		logic [7:0]  current_alt;
		usb_state_t  usb_state;
		logic [8:0]  prog_len;
		logic [11:0] buf_offset;
		logic [31:0] flash_addr;
		flash_cmd_t  flash_cmd;
		logic        accepted;
	} result_t;

endpackage

/* sv/dfu_core.sv */
module dfu_core #(
	parameter int TICK_DIVIDE = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  dfu_pkg::opcode_t   op,
	input  dfu_pkg::in_data_t  data,
	output dfu_pkg::result_t   res
);

	localparam int TICK_W = (TICK_DIVIDE > 0) ? $clog2(TICK_DIVIDE + 1) : 1;
	localparam logic [TICK_W-1:0] TICK_LAST = TICK_W'(TICK_DIVIDE);

	// State
	dfu_pkg::usb_state_t mode_q, mode_d;
	logic [TICK_W-1:0]   tick_q, tick_d;
	logic [7:0]          slot_q, slot_d;
	logic [31:0]         base_q, base_d;
	logic [31:0]         erase_q, erase_d;
	logic [12:0]         off_q, off_d;
	logic [12:0]         len_q, len_d;
	dfu_pkg::phase_t     phase_q, phase_d;
	logic                ready_q, ready_d;

	// Flash step results
	dfu_pkg::flash_cmd_t fs_cmd;
	logic [31:0]         fs_addr;
	logic [12:0]         fs_len;
	dfu_pkg::phase_t     fs_phase;
	logic [31:0]         fs_erase;
	logic [12:0]         fs_off;
	logic                fs_ready;
	logic                fs_done;

	logic intf_match;
	logic issue;

	assign intf_match = (data.intf_class == dfu_pkg::INTF_CLASS)
		&& (data.intf_subclass == dfu_pkg::INTF_SUBCLASS)
		&& (data.intf_protocol == dfu_pkg::INTF_PROTOCOL);

	assign issue = (op == dfu_pkg::OP_TICK) && (tick_q == TICK_LAST);

	// Erase sectors, then program page-bounded chunks once data is in
	always_comb begin
		logic [31:0] end_addr;
		logic [31:0] where;
		logic [12:0] rem;
		logic [12:0] room;
		logic [12:0] plen;
		end_addr = base_q + 32'(len_q);
		where    = base_q + 32'(off_q);
		rem      = len_q - off_q;
		room     = 13'(dfu_pkg::PAGE_BYTES) - 13'(where[dfu_pkg::PAGE_W-1:0]);
		plen     = (rem > room) ? room : rem;
		fs_cmd   = dfu_pkg::CMD_NONE;
		fs_addr  = '0;
		fs_len   = '0;
		fs_phase = phase_q;
		fs_erase = erase_q;
		fs_off   = off_q;
		fs_ready = ready_q;
		fs_done  = 1'b0;
		if (phase_q != dfu_pkg::PH_IDLE && !data.flash_busy
				&& !(phase_q == dfu_pkg::PH_PROGRAM && !ready_q)) begin
			if (phase_q == dfu_pkg::PH_ERASE) begin
				if (erase_q >= end_addr) begin
					fs_phase = dfu_pkg::PH_PROGRAM;
				end else begin
					fs_cmd   = dfu_pkg::CMD_ERASE;
					fs_addr  = erase_q;
					fs_erase = erase_q + 32'(dfu_pkg::SECTOR_BYTES);
				end
			end
			if (fs_phase == dfu_pkg::PH_PROGRAM && ready_q) begin
				if (off_q >= len_q) begin
					fs_phase = dfu_pkg::PH_IDLE;
					fs_ready = 1'b0;
					fs_done  = 1'b1;
				end else begin
					fs_cmd  = dfu_pkg::CMD_PROGRAM;
					fs_addr = where;
					fs_len  = plen;
					fs_off  = off_q + plen;
				end
			end
		end
	end

	// Next state
	always_comb begin
		logic [12:0] n;
		logic [31:0] slot_base;
		n         = (data.length > 13'(dfu_pkg::BUF_BYTES)) ?
			13'(dfu_pkg::BUF_BYTES) : data.length;
		slot_base = dfu_pkg::SLOT_ORIGIN + (32'(data.alt_setting) << dfu_pkg::SLOT_SHIFT);
		mode_d  = mode_q;
		tick_d  = tick_q;
		slot_d  = slot_q;
		base_d  = base_q;
		erase_d = erase_q;
		off_d   = off_q;
		len_d   = len_q;
		phase_d = phase_q;
		ready_d = ready_q;
		unique case (op) inside
			dfu_pkg::OP_TICK: begin
				if (tick_q != TICK_LAST) begin
					tick_d = tick_q + 1'b1;
				end else begin
					tick_d  = '0;
					phase_d = fs_phase;
					erase_d = fs_erase;
					off_d   = fs_off;
					ready_d = fs_ready;
					if (fs_done) begin
						mode_d = dfu_pkg::ST_DN_SYNC;
						base_d = base_q + 32'(len_q);
					end
				end
			end
			dfu_pkg::OP_DNLOAD: begin
				if (n != '0) begin
					mode_d  = dfu_pkg::ST_DN_SYNC;
					off_d   = '0;
					len_d   = n;
					phase_d = dfu_pkg::PH_ERASE;
					ready_d = 1'b0;
				end else begin
					mode_d = dfu_pkg::ST_IDLE;
				end
			end
			dfu_pkg::OP_DATA_RCVD: begin
				if (phase_q != dfu_pkg::PH_IDLE) begin
					mode_d  = dfu_pkg::ST_DN_BUSY;
					ready_d = 1'b1;
				end
			end
			dfu_pkg::OP_GET_STATUS: begin
				if (mode_q == dfu_pkg::ST_DN_SYNC) begin
					mode_d = dfu_pkg::ST_DN_IDLE;
				end else if (mode_q == dfu_pkg::ST_MF_SYNC) begin
					mode_d = dfu_pkg::ST_MF;
				end
			end
			dfu_pkg::OP_SET_INTF: begin
				if (intf_match) begin
					slot_d  = data.alt_setting;
					mode_d  = dfu_pkg::ST_IDLE;
					base_d  = slot_base;
					erase_d = slot_base;
				end
			end
			default: begin
			end
		endcase
	end

	// Result fields
	always_comb begin
		res = '0;
		unique case (op) inside
			dfu_pkg::OP_TICK, dfu_pkg::OP_DNLOAD, dfu_pkg::OP_GET_STATUS,
			dfu_pkg::OP_GET_STATE, dfu_pkg::OP_CLR_STATUS, dfu_pkg::OP_ABORT:
				res.accepted = 1'b1;
			dfu_pkg::OP_DATA_RCVD: res.accepted = (phase_q != dfu_pkg::PH_IDLE);
			dfu_pkg::OP_SET_INTF, dfu_pkg::OP_GET_INTF: res.accepted = intf_match;
			default: res.accepted = 1'b0;
		endcase
		if (issue) begin
			res.flash_cmd  = fs_cmd;
			res.flash_addr = fs_addr;
			if (fs_cmd == dfu_pkg::CMD_PROGRAM) begin
				res.buf_offset = off_q[11:0];
			end
			res.prog_len   = fs_len[8:0];
		end
		res.usb_state   = mode_d;
		res.current_alt = slot_d;
	end

	// Hold state between transactions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= dfu_pkg::ST_APP_IDLE;
			tick_q  <= '0;
			slot_q  <= '0;
			base_q  <= '0;
			erase_q <= '0;
			off_q   <= '0;
			len_q   <= '0;
			phase_q <= dfu_pkg::PH_IDLE;
			ready_q <= 1'b0;
		end else if (en) begin
			mode_q  <= mode_d;
			tick_q  <= tick_d;
			slot_q  <= slot_d;
			base_q  <= base_d;
			erase_q <= erase_d;
			off_q   <= off_d;
			len_q   <= len_d;
			phase_q <= phase_d;
			ready_q <= ready_d;
		end
	end

`ifndef SYNTH
	a_ready_needs_phase: assert property (@(posedge clk) disable iff (!arst_n)
		ready_q |-> phase_q != dfu_pkg::PH_IDLE)
		else $error("data ready set with no download armed");

	a_offset_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(off_q <= len_q) && (len_q <= 13'(dfu_pkg::BUF_BYTES)))
		else $error("chunk offset or length out of range");

	a_cmd_only_on_issue: assert property (@(posedge clk) disable iff (!arst_n)
		en && res.flash_cmd != dfu_pkg::CMD_NONE |-> issue)
		else $error("flash command outside an issuing tick");

	a_page_bound: assert property (@(posedge clk) disable iff (!arst_n)
		en && res.flash_cmd == dfu_pkg::CMD_PROGRAM |->
			(14'(res.flash_addr[dfu_pkg::PAGE_W-1:0]) + 14'(fs_len))
				<= 14'(dfu_pkg::PAGE_BYTES) && fs_len != '0)
		else $error("page program crosses a page");

	a_tick_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		en && issue |=> tick_q == '0)
		else $error("tick divider did not wrap");
`endif

endmodule

/* sv/dfu_flash_update_sequencer.sv */
// DFU download sequencer.
// Input channel s_*: one transaction per event; s_tuser carries the opcode
// (tick, download request, data received, status/state queries, interface
// select/query), s_tdata the request arguments and the flash busy bit.
// Output channel m_*: exactly one result transaction per event, in order,
// with the accept flag, any flash command (sector erase or page program with
// address, buffer offset and length), the DFU state and the selected slot.
// Every TICK_DIVIDE+1 ticks one tick may issue a flash command.
// An input transaction passes the input register, then the result register,
// before its result is valid. Throughput: one event per cycle while the
// receiver does not stall; the state update is a single pass of logic between the two registers.
// When the receiver stalls, the result register holds and the input register
// takes one more event; after that s_tready drops until m_tready returns.
// Reset (arst_n low) clears both register valids and puts the DFU state in
// application idle with all pointers, the slot and the tick divider at zero.
module dfu_flash_update_sequencer #(
	parameter int TICK_DIVIDE = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// length[12:0], alt_setting[20:13], intf_class[28:21], intf_subclass[36:29],
	// intf_protocol[44:37], flash_busy[45], zero pad[47:46]
	input  logic [47:0] s_tdata,
	// opcode[3:0]
	input  logic [3:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// accepted[0], flash_cmd[2:1], flash_addr[34:3], buf_offset[46:35],
	// prog_len[55:47], usb_state[59:56], current_alt[67:60], zero pad[71:68]
	output logic [71:0] m_tdata
);

	logic              valid_s1;
	dfu_pkg::opcode_t  op_s1;
	dfu_pkg::in_data_t data_s1;
	logic              m_valid_q;
	dfu_pkg::result_t  result_q;
	dfu_pkg::result_t  result;
	logic              advance;

	// Move the held event into the result register when it has room
	assign advance  = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1   <= dfu_pkg::opcode_t'(s_tuser);
			data_s1 <= dfu_pkg::in_data_t'(s_tdata[45:0]);
		end
	end

	dfu_core #(
		.TICK_DIVIDE(TICK_DIVIDE)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (advance),
		.op    (op_s1),
		.data  (data_s1),
		.res   (result)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {4'b0, result_q};

endmodule
